// File: src/srfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfc_pkg
// Shared types and constants of the skin run finger counter.
// ----------------------------------------------------------------------------
package srfc_pkg;

	// run table
	localparam int MAX_RUNS     = 20;
	localparam int BAND_COLUMNS = 20;
	localparam int KIDX_W       = $clog2(MAX_RUNS);
	localparam int KCNT_W       = $clog2(MAX_RUNS + 1);
	localparam int LEN_W        = 12;
	localparam int ENTRY_W      = LEN_W + 1;
	localparam int FING_W       = 5;
	localparam int VOTE_W       = 12;

	// queue between front and back
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// skin test, coefficients scaled by 1000
	localparam int PROD_W      = 25;
	localparam int NUM_W       = 27;
	localparam int COEF_CB_R   = 37797;
	localparam int COEF_CB_G   = 74203;
	localparam int COEF_CB_B   = 112000;
	localparam int COEF_CR_R   = 112000;
	localparam int COEF_CR_G   = 93786;
	localparam int COEF_CR_B   = 18214;
	localparam int NUM_OFFSET  = 32768000;
	localparam int SKIN_SCALE  = 256000;
	localparam int CB_LO       = 96;
	localparam int CB_HI       = 143;
	localparam int CR_LO       = 132;
	localparam int CR_HI       = 180;
	localparam int CB_NUM_LO   = (CB_LO + 1) * SKIN_SCALE;
	localparam int CB_NUM_HI   = CB_HI * SKIN_SCALE;
	localparam int CR_NUM_LO   = (CR_LO + 1) * SKIN_SCALE;
	localparam int CR_NUM_HI   = CR_HI * SKIN_SCALE;

	// register indexes
	localparam logic [1:0] REG_ROW_WIDTH    = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MIN_RUN      = 2'd2;

	localparam logic [11:0] RESET_ROW_WIDTH    = 12'd640;
	localparam logic [11:0] RESET_FRAME_HEIGHT = 12'd480;
	localparam logic [7:0]  RESET_MIN_RUN      = 8'd8;

	// finger counts that vote
	localparam logic [FING_W-1:0] FING_STONE   = 5'd1;
	localparam logic [FING_W-1:0] FING_SCISSOR = 5'd2;
	localparam logic [FING_W-1:0] FING_PAPER   = 5'd4;

	localparam logic [1:0] GEST_STONE   = 2'd0;
	localparam logic [1:0] GEST_SCISSOR = 2'd1;
	localparam logic [1:0] GEST_PAPER   = 2'd2;

	typedef struct packed {
		logic [11:0] row_width;
		logic [11:0] frame_height;
		logic [7:0]  min_run;
	} cfg_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              empty;
		logic              head;
	} q_status_t;

	typedef enum logic [0:0] {
		BK_RUN,
		BK_COUNT
	} bk_state_t;

endpackage

// File: src/srfc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module srfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/srfc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfc_front
// Accepts pixels and classifies them as skin in two stages.
// ----------------------------------------------------------------------------
module srfc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 red,
	input  logic [7:0]                 green,
	input  logic [7:0]                 blue,
	input  logic [srfc_pkg::QCNT_W-1:0] q_count,
	output logic                       push,
	output logic                       push_skin
);

	localparam int PW = srfc_pkg::PROD_W;
	localparam int NW = srfc_pkg::NUM_W;

	logic          valid_s1;
	logic          valid_s2;
	logic          skin_s2;
	logic [PW-1:0] cb_r_s1, cb_g_s1, cb_b_s1;
	logic [PW-1:0] cr_r_s1, cr_g_s1, cr_b_s1;
	logic [NW-1:0] num_cb;
	logic [NW-1:0] num_cr;
	logic          take;
	logic [srfc_pkg::QCNT_W:0] reserved;

	// hold off while the queue cannot absorb every beat in flight
	assign reserved = {1'b0, q_count} + (srfc_pkg::QCNT_W+1)'(valid_s1)
		+ (srfc_pkg::QCNT_W+1)'(valid_s2);
	assign in_stall = reserved >= (srfc_pkg::QCNT_W+1)'(srfc_pkg::QDEPTH);
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		cb_r_s1 <= PW'(srfc_pkg::COEF_CB_R) * PW'(red);
		cb_g_s1 <= PW'(srfc_pkg::COEF_CB_G) * PW'(green);
		cb_b_s1 <= PW'(srfc_pkg::COEF_CB_B) * PW'(blue);
		cr_r_s1 <= PW'(srfc_pkg::COEF_CR_R) * PW'(red);
		cr_g_s1 <= PW'(srfc_pkg::COEF_CR_G) * PW'(green);
		cr_b_s1 <= PW'(srfc_pkg::COEF_CR_B) * PW'(blue);
	end

	// numerators stay positive, so floor division becomes plain bounds
	assign num_cb = NW'(srfc_pkg::NUM_OFFSET) + NW'(cb_b_s1) - NW'(cb_r_s1) - NW'(cb_g_s1);
	assign num_cr = NW'(srfc_pkg::NUM_OFFSET) + NW'(cr_r_s1) - NW'(cr_g_s1) - NW'(cr_b_s1);

	always_ff @(posedge clk) begin
		skin_s2 <= (num_cb >= NW'(srfc_pkg::CB_NUM_LO)) && (num_cb < NW'(srfc_pkg::CB_NUM_HI))
			&& (num_cr >= NW'(srfc_pkg::CR_NUM_LO)) && (num_cr < NW'(srfc_pkg::CR_NUM_HI));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	assign push      = valid_s2;
	assign push_skin = skin_s2;

endmodule

// File: src/srfc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfc_queue
// Short queue of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module srfc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  push_skin,
	input  logic                  pop,
	output srfc_pkg::q_status_t   status
);

	logic                          mem_q [srfc_pkg::QDEPTH];
	logic [srfc_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [srfc_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [srfc_pkg::QCNT_W-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_skin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + srfc_pkg::QCNT_W'(push) - srfc_pkg::QCNT_W'(pop);
		end
	end

	assign status.count = count_q;
	assign status.empty = (count_q == '0);
	assign status.head  = mem_q[rd_ptr_q];

endmodule

// File: src/srfc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srfc_back
// Run bookkeeping, finger decision, band tint, row vote and gesture.
// ----------------------------------------------------------------------------
module srfc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  srfc_pkg::cfg_t      cfg,
	input  srfc_pkg::q_status_t q_status,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_red,
	output logic [7:0]          out_green,
	output logic [7:0]          out_blue,
	output logic                skin_flag,
	output logic                row_done,
	output logic [4:0]          finger_count,
	output logic                frame_done,
	output logic [1:0]          gesture
);

	localparam int LW = srfc_pkg::LEN_W;
	localparam int KW = srfc_pkg::KCNT_W;
	localparam int IW = srfc_pkg::KIDX_W;
	localparam int FW = srfc_pkg::FING_W;
	localparam int VW = srfc_pkg::VOTE_W;
	localparam logic [LW-1:0] LEN_MAX  = '1;
	localparam logic [VW-1:0] VOTE_MAX = '1;
	localparam logic [FW-1:0] FING_MAX = '1;

	srfc_pkg::bk_state_t state_q, state_d;

	logic [11:0]   column_q, row_q;
	logic          run_is_skin_q;
	logic [LW-1:0] run_length_q;
	logic [KW-1:0] kept_count_q;
	logic          last_kind_q;
	logic [LW-1:0] last_len_q;
	logic [FW-1:0] row_fingers_q;
	logic [LW-1:0] longest_bg_q;
	logic [VW-1:0] votes_q [3];
	logic [KW-1:0] rd_idx_q;
	logic          pend_q;
	logic [FW-1:0] hits_q;
	logic          out_valid_q;

	logic [11:0]   w, h;
	logic [12:0]   col_p1, col_pb, row_p1;
	logic          in_band, at_decision, row_end, frame_end;
	logic          out_free, take, skin;
	logic          do_rec, merge, append, stored;
	logic [12:0]   len_sum;
	logic [LW-1:0] merged_len, stored_len, lb_next;
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [srfc_pkg::ENTRY_W-1:0] ram_rdata;
	logic [16:0]   len_x20;
	logic          hit, issue, done;
	logic [VW-1:0] votes_d [3];
	logic [14:0]   stone_x2, scissor_x5, paper_x5;
	logic [1:0]    gest_d;
	logic [7:0]    r_d, g_d, b_d;

	assign w = (cfg.row_width == '0) ? 12'd1 : cfg.row_width;
	assign h = (cfg.frame_height == '0) ? 12'd1 : cfg.frame_height;

	assign col_p1      = {1'b0, column_q} + 13'd1;
	assign col_pb      = {1'b0, column_q} + 13'(srfc_pkg::BAND_COLUMNS);
	assign row_p1      = {1'b0, row_q} + 13'd1;
	assign in_band     = col_pb > {1'b0, w};
	assign at_decision = col_pb == {1'b0, w};
	assign row_end     = col_p1 >= {1'b0, w};
	assign frame_end   = row_end && (row_p1 >= {1'b0, h});

	assign out_free = !out_valid_q || !out_stall;
	assign skin     = q_status.head;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			srfc_pkg::BK_RUN: begin
				if (take && at_decision) begin
					state_d = srfc_pkg::BK_COUNT;
				end
			end
			srfc_pkg::BK_COUNT: begin
				if (done) begin
					state_d = srfc_pkg::BK_RUN;
				end
			end
			default: state_d = srfc_pkg::BK_RUN;
		endcase
	end

	// control outputs
	always_comb begin
		take  = 1'b0;
		issue = 1'b0;
		done  = 1'b0;
		case (state_q)
			srfc_pkg::BK_RUN: begin
				take = !q_status.empty && out_free;
			end
			srfc_pkg::BK_COUNT: begin
				issue = rd_idx_q < kept_count_q;
				done  = !issue && !pend_q;
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	assign pop = take;

	// close the ending run into the table
	assign do_rec     = take && (skin != run_is_skin_q)
		&& (run_length_q > LW'(cfg.min_run));
	assign merge      = (kept_count_q != '0) && (last_kind_q == run_is_skin_q);
	assign append     = !merge && (kept_count_q < KW'(srfc_pkg::MAX_RUNS));
	assign stored     = do_rec && (merge || append);
	assign len_sum    = {1'b0, last_len_q} + {1'b0, run_length_q};
	assign merged_len = len_sum[12] ? LEN_MAX : len_sum[LW-1:0];
	assign stored_len = merge ? merged_len : run_length_q;
	assign lb_next    = (stored && !run_is_skin_q && (stored_len > longest_bg_q))
		? stored_len : longest_bg_q;

	assign ram_we = stored;
	always_comb begin
		logic [KW-1:0] last_idx;
		last_idx  = kept_count_q - 1'b1;
		ram_waddr = merge ? last_idx[IW-1:0] : kept_count_q[IW-1:0];
	end

	srfc_ram #(
		.WIDTH (srfc_pkg::ENTRY_W),
		.DEPTH (srfc_pkg::MAX_RUNS)
	) u_runs (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({run_is_skin_q, stored_len}),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	// count pass compares one table entry a cycle
	assign len_x20 = ({5'b0, ram_rdata[LW-1:0]} << 4) + ({5'b0, ram_rdata[LW-1:0]} << 2);
	assign hit     = pend_q && ram_rdata[LW] && (len_x20 >= {5'b0, longest_bg_q});

	// votes and gesture
	always_comb begin
		votes_d[0] = votes_q[0];
		votes_d[1] = votes_q[1];
		votes_d[2] = votes_q[2];
		if (row_fingers_q == srfc_pkg::FING_STONE && votes_q[0] != VOTE_MAX) begin
			votes_d[0] = votes_q[0] + 1'b1;
		end else if (row_fingers_q == srfc_pkg::FING_SCISSOR && votes_q[1] != VOTE_MAX) begin
			votes_d[1] = votes_q[1] + 1'b1;
		end else if (row_fingers_q == srfc_pkg::FING_PAPER && votes_q[2] != VOTE_MAX) begin
			votes_d[2] = votes_q[2] + 1'b1;
		end
	end

	assign stone_x2   = {2'b0, votes_d[0], 1'b0};
	assign scissor_x5 = ({3'b0, votes_d[1]} << 2) + {3'b0, votes_d[1]};
	assign paper_x5   = ({3'b0, votes_d[2]} << 2) + {3'b0, votes_d[2]};

	always_comb begin
		if (paper_x5 > stone_x2) begin
			gest_d = srfc_pkg::GEST_PAPER;
		end else if (scissor_x5 > stone_x2) begin
			gest_d = srfc_pkg::GEST_SCISSOR;
		end else begin
			gest_d = srfc_pkg::GEST_STONE;
		end
	end

	// pixel color with band tint
	always_comb begin
		r_d = skin ? 8'hFF : 8'h00;
		g_d = r_d;
		b_d = r_d;
		if (in_band) begin
			case (row_fingers_q)
				srfc_pkg::FING_STONE: begin
					r_d = 8'hFF; g_d = 8'h00; b_d = 8'h00;
				end
				srfc_pkg::FING_SCISSOR: begin
					r_d = 8'h00; g_d = 8'h00; b_d = 8'hFF;
				end
				srfc_pkg::FING_PAPER: begin
					r_d = 8'h00; g_d = 8'hFF; b_d = 8'h00;
				end
				default: begin
					r_d = r_d;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= srfc_pkg::BK_RUN;
			column_q      <= '0;
			row_q         <= '0;
			run_is_skin_q <= 1'b0;
			run_length_q  <= '0;
			kept_count_q  <= '0;
			last_kind_q   <= 1'b0;
			last_len_q    <= '0;
			row_fingers_q <= '0;
			longest_bg_q  <= '0;
			votes_q[0]    <= '0;
			votes_q[1]    <= '0;
			votes_q[2]    <= '0;
			rd_idx_q      <= '0;
			pend_q        <= 1'b0;
			hits_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (take) begin
				// run tracking
				if (skin == run_is_skin_q) begin
					if (run_length_q != LEN_MAX) begin
						run_length_q <= run_length_q + 1'b1;
					end
				end else begin
					run_is_skin_q <= skin;
					run_length_q  <= LW'(1);
				end
				if (stored) begin
					last_kind_q <= run_is_skin_q;
					last_len_q  <= stored_len;
					if (!merge) begin
						kept_count_q <= kept_count_q + 1'b1;
					end
				end
				longest_bg_q <= lb_next;

				if (at_decision) begin
					rd_idx_q <= '0;
					pend_q   <= 1'b0;
					hits_q   <= '0;
				end

				if (row_end) begin
					run_is_skin_q <= 1'b0;
					run_length_q  <= '0;
					kept_count_q  <= '0;
					row_fingers_q <= '0;
					column_q      <= '0;
					if (frame_end) begin
						row_q        <= '0;
						longest_bg_q <= '0;
						votes_q[0]   <= '0;
						votes_q[1]   <= '0;
						votes_q[2]   <= '0;
					end else begin
						row_q      <= row_p1[11:0];
						votes_q[0] <= votes_d[0];
						votes_q[1] <= votes_d[1];
						votes_q[2] <= votes_d[2];
					end
				end else begin
					column_q <= col_p1[11:0];
				end
			end

			if (state_q == srfc_pkg::BK_COUNT) begin
				pend_q <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (hit && hits_q != FING_MAX) begin
					hits_q <= hits_q + 1'b1;
				end
				if (done) begin
					row_fingers_q <= hits_q;
				end
			end
		end
	end

	// output register, loaded on every taken beat
	always_ff @(posedge clk) begin
		if (take) begin
			out_red      <= r_d;
			out_green    <= g_d;
			out_blue     <= b_d;
			skin_flag    <= skin;
			row_done     <= row_end;
			finger_count <= row_end ? row_fingers_q : 5'd0;
			frame_done   <= frame_end;
			gesture      <= frame_end ? gest_d : srfc_pkg::GEST_STONE;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: src/skin_run_finger_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skin_run_finger_counter
// Skin classification, run segmentation and finger count per row, with a
// stone / scissor / paper vote per frame.
// Path of a pixel: front registers s1 and s2, queue entry, back output register.
// Throughput: one pixel per cycle unless the output stalls, except at the decision
// column of each row, where the back end walks the run table one entry a cycle.
// Reset: registers return to defaults, counters and queue clear; the run table
// RAM is not cleared, only entries written in the current row are read.
// ----------------------------------------------------------------------------
module skin_run_finger_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [11:0] wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        skin_flag,
	output logic        row_done,
	output logic [4:0]  finger_count,
	output logic        frame_done,
	output logic [1:0]  gesture
);

	srfc_pkg::cfg_t      cfg_q;
	srfc_pkg::q_status_t q_status;
	logic                push;
	logic                push_skin;
	logic                pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_width    <= srfc_pkg::RESET_ROW_WIDTH;
			cfg_q.frame_height <= srfc_pkg::RESET_FRAME_HEIGHT;
			cfg_q.min_run      <= srfc_pkg::RESET_MIN_RUN;
		end else if (wr_en) begin
			case (wr_index)
				srfc_pkg::REG_ROW_WIDTH:    cfg_q.row_width    <= wr_data;
				srfc_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= wr_data;
				srfc_pkg::REG_MIN_RUN:      cfg_q.min_run      <= wr_data[7:0];
				default:                    cfg_q              <= cfg_q;
			endcase
		end
	end

	srfc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.q_count   (q_status.count),
		.push      (push),
		.push_skin (push_skin)
	);

	srfc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_skin (push_skin),
		.pop       (pop),
		.status    (q_status)
	);

	srfc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.skin_flag    (skin_flag),
		.row_done     (row_done),
		.finger_count (finger_count),
		.frame_done   (frame_done),
		.gesture      (gesture)
	);

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for skin_run_finger_counter. Streams RGB pixels and
// keeps a cycle-free model of the skin test, the run table, the finger count,
// the band tint and the frame vote. Every output beat is checked in order
// against the model. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import srfc_pkg::*;

	localparam int         RUN_LEN_MAX = 4095;
	localparam int         VOTE_MAX    = 4095;
	localparam logic [1:0] REG_UNUSED  = 2'd3;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       skin;
		logic       row_end;
		logic [4:0] fingers;
		logic       frame_end;
		logic [1:0] gest;
	} marked_px_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [11:0] wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  red, green, blue;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_red, out_green, out_blue;
	logic        skin_flag, row_done, frame_done;
	logic [4:0]  finger_count;
	logic [1:0]  gesture;

	skin_run_finger_counter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.skin_flag    (skin_flag),
		.row_done     (row_done),
		.finger_count (finger_count),
		.frame_done   (frame_done),
		.gesture      (gesture)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model state
	int cfg_row_w, cfg_height, cfg_min_run;
	int px_col, px_row, cur_skin, cur_len;
	bit tab_skin [MAX_RUNS];
	int tab_len [MAX_RUNS];
	int kept_n, row_fing, longest_bg;
	int votes [3];

	marked_px_t marked_px_q[$];
	bit no_gaps;
	int mismatches, beats_seen, rows_seen, frames_seen;
	int gest_seen [3];

	function automatic bit is_skin_tone(input logic [7:0] r, input logic [7:0] g,
		input logic [7:0] b);
		int ri, gi, bi, cb, cr;
		ri = r;
		gi = g;
		bi = b;
		cb = (NUM_OFFSET - COEF_CB_R * ri - COEF_CB_G * gi + COEF_CB_B * bi) / SKIN_SCALE;
		cr = (NUM_OFFSET + COEF_CR_R * ri - COEF_CR_G * gi - COEF_CR_B * bi) / SKIN_SCALE;
		return cb > CB_LO && cb < CB_HI && cr > CR_LO && cr < CR_HI;
	endfunction

	function automatic void clear_row_runs();
		cur_skin = 0;
		cur_len  = 0;
		kept_n   = 0;
		row_fing = 0;
		for (int k = 0; k < MAX_RUNS; k++) begin
			tab_skin[k] = 1'b0;
			tab_len[k]  = 0;
		end
	endfunction

	function automatic void reset_model();
		cfg_row_w   = RESET_ROW_WIDTH;
		cfg_height  = RESET_FRAME_HEIGHT;
		cfg_min_run = RESET_MIN_RUN;
		px_col      = 0;
		px_row      = 0;
		clear_row_runs();
		longest_bg  = 0;
		votes       = '{0, 0, 0};
	endfunction

	// close a run longer than min_run: merge into the last entry of the same kind, else append if room
	function automatic void keep_run(input bit kind, input int len);
		bit stored;
		int sum;
		stored = 1'b0;
		if (len <= cfg_min_run)
			return;
		if (kept_n > 0 && tab_skin[kept_n-1] == kind) begin
			sum = tab_len[kept_n-1] + len;
			len = sum > RUN_LEN_MAX ? RUN_LEN_MAX : sum;
			tab_len[kept_n-1] = len;
			stored = 1'b1;
		end else if (kept_n < MAX_RUNS) begin
			tab_skin[kept_n] = kind;
			tab_len[kept_n]  = len;
			kept_n++;
			stored = 1'b1;
		end
		if (stored && !kind && len > longest_bg)
			longest_bg = len;
	endfunction

	function automatic marked_px_t predict_marked_pixel(input logic [7:0] r,
		input logic [7:0] g, input logic [7:0] b);
		marked_px_t res;
		int w, h, band, n;
		bit skin;
		res  = '0;
		w    = cfg_row_w == 0 ? 1 : cfg_row_w;
		h    = cfg_height == 0 ? 1 : cfg_height;
		band = w - BAND_COLUMNS;
		skin = is_skin_tone(r, g, b);

		if (skin == cur_skin) begin
			if (cur_len < RUN_LEN_MAX)
				cur_len++;
		end else begin
			keep_run(cur_skin, cur_len);
			cur_skin = skin;
			cur_len  = 1;
		end
		if (skin) begin
			res.red   = 8'hFF;
			res.green = 8'hFF;
			res.blue  = 8'hFF;
		end

		if (px_col > band) begin
			if (row_fing == FING_STONE) begin
				res.red = 8'hFF; res.green = 8'h00; res.blue = 8'h00;
			end else if (row_fing == FING_SCISSOR) begin
				res.red = 8'h00; res.green = 8'h00; res.blue = 8'hFF;
			end else if (row_fing == FING_PAPER) begin
				res.red = 8'h00; res.green = 8'hFF; res.blue = 8'h00;
			end
		end

		if (px_col == band) begin
			n = 0;
			for (int k = 0; k < kept_n; k++)
				if (tab_skin[k] && 20 * tab_len[k] >= longest_bg)
					n++;
			row_fing = n > 31 ? 31 : n;
		end

		res.skin = skin;
		if (px_col + 1 >= w) begin
			res.row_end = 1'b1;
			res.fingers = 5'(row_fing);
			if (row_fing == FING_STONE && votes[0] < VOTE_MAX)
				votes[0]++;
			else if (row_fing == FING_SCISSOR && votes[1] < VOTE_MAX)
				votes[1]++;
			else if (row_fing == FING_PAPER && votes[2] < VOTE_MAX)
				votes[2]++;
			clear_row_runs();
			px_col = 0;
			if (px_row + 1 >= h) begin
				res.frame_end = 1'b1;
				if (5 * votes[2] > 2 * votes[0])
					res.gest = GEST_PAPER;
				else if (5 * votes[1] > 2 * votes[0])
					res.gest = GEST_SCISSOR;
				else
					res.gest = GEST_STONE;
				votes      = '{0, 0, 0};
				longest_bg = 0;
				px_row     = 0;
			end else begin
				px_row++;
			end
		end else begin
			px_col = (px_col + 1) & 12'hFFF;
		end
		return res;
	endfunction

	// ------------------------------------------------------------------
	// drivers

	always @(posedge clk)
		out_stall <= no_gaps ? 1'b0 : ($urandom_range(99) < 38);

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		if (!no_gaps)
			while ($urandom_range(99) < 38) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		marked_px_q.push_back(predict_marked_pixel(r, g, b));
	endtask

	function automatic rgb_t pick_color(input bit want_skin);
		rgb_t c;
		for (int t = 0; t < 64; t++) begin
			if (want_skin) begin
				c.r = 8'($urandom_range(255, 140));
				c.g = 8'($urandom_range(170, 70));
				c.b = 8'($urandom_range(180, 60));
			end else begin
				c.r = 8'($urandom_range(255));
				c.g = 8'($urandom_range(255));
				c.b = 8'($urandom_range(255));
			end
			if (is_skin_tone(c.r, c.g, c.b) == want_skin)
				return c;
		end
		return want_skin ? rgb_t'({8'd200, 8'd120, 8'd100}) : rgb_t'(24'h0);
	endfunction

	task automatic send_kind(input bit want_skin);
		rgb_t c;
		c = pick_color(want_skin);
		send_pixel(c.r, c.g, c.b);
	endtask

	// hold off the sender until every pending pixel is back, then let the
	// decision walk settle
	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (marked_px_q.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ROW_WIDTH:    cfg_row_w   = data;
			REG_FRAME_HEIGHT: cfg_height  = data;
			REG_MIN_RUN:      cfg_min_run = data[7:0];
			default: ;
		endcase
	endtask

	task automatic set_frame(input logic [11:0] w, input logic [11:0] h,
		input logic [11:0] mr);
		wait_results_done();
		write_reg(REG_ROW_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_MIN_RUN, mr);
	endtask

	task automatic send_row_kinds(ref bit run_kinds[$]);
		while (run_kinds.size() < cfg_row_w)
			run_kinds.push_back(1'b0);
		for (int k = 0; k < cfg_row_w; k++)
			send_kind(run_kinds[k]);
	endtask

	// ------------------------------------------------------------------
	// tests

	task automatic test_color_extremes();
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		send_pixel(8'hFF, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hFF, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hFF);
		send_pixel(8'd200, 8'd120, 8'd100);
		send_pixel(8'hFF, 8'hFF, 8'h00);
		send_pixel(8'h00, 8'hFF, 8'hFF);
		send_pixel(8'hFF, 8'h00, 8'hFF);
		send_pixel(8'd200, 8'd120, 8'd100);
	endtask

	// zero sizes count as one; narrow rows are all band; min_run keeps 8 bits
	task automatic test_tiny_frames();
		set_frame(12'd0, 12'd0, 12'd0);
		write_reg(REG_UNUSED, 12'hABC);
		repeat (4) send_kind(1'($urandom_range(1)));
		set_frame(12'd5, 12'd2, 12'hFFF);
		for (int k = 0; k < 10; k++)
			send_kind(k[0] ^ k[2]);
	endtask

	// long background run at the widest row, then shrink width and height
	// below the current column and row
	task automatic test_long_run_resize();
		set_frame(12'd4095, 12'd4095, 12'd100);
		repeat (110) send_kind(1'b0);
		repeat (6) send_kind(1'b1);
		wait_results_done();
		write_reg(REG_ROW_WIDTH, 12'd21);
		repeat (6) send_kind(1'b0);
		wait_results_done();
		write_reg(REG_FRAME_HEIGHT, 12'd1);
		repeat (16) send_kind(1'b1);
	endtask

	// a skin run of 2 pixels counts against a 30-pixel background, a run of 1 does not
	task automatic test_finger_threshold();
		bit run_kinds[$];
		set_frame(12'd60, 12'd1, 12'd0);
		repeat (30) run_kinds.push_back(1'b0);
		run_kinds.push_back(1'b1);
		run_kinds.push_back(1'b1);
		run_kinds.push_back(1'b0);
		run_kinds.push_back(1'b1);
		send_row_kinds(run_kinds);
	endtask

	// single-pixel runs overflow the run table
	task automatic test_table_full();
		bit run_kinds[$];
		set_frame(12'd70, 12'd1, 12'd0);
		for (int k = 0; k < 50; k++)
			run_kinds.push_back(~k[0]);
		send_row_kinds(run_kinds);
	endtask

	task automatic send_hand_row(input int fingers);
		bit run_kinds[$];
		int n;
		n = $urandom_range(6, 4);
		repeat (n) run_kinds.push_back(1'b0);
		for (int i = 0; i < fingers; i++) begin
			// a short dark gap inside a finger gets dropped along with the short half before it
			if ($urandom_range(9) == 0) begin
				repeat (2) run_kinds.push_back(1'b1);
				n = $urandom_range(2, 1);
				repeat (n) run_kinds.push_back(1'b0);
			end
			n = $urandom_range(5, 4);
			repeat (n) run_kinds.push_back(1'b1);
			n = $urandom_range(5, 4);
			repeat (n) run_kinds.push_back(1'b0);
		end
		while (run_kinds.size() < cfg_row_w)
			run_kinds.push_back($urandom_range(9) == 0);
		send_row_kinds(run_kinds);
	endtask

	task automatic test_hand_frames();
		int target [3];
		int fingers;
		target = '{FING_STONE, FING_SCISSOR, FING_PAPER};
		set_frame(12'd70, 12'd1, 12'd3);
		for (int f = 0; f < 5; f++) begin
			no_gaps <= (f == 3);
			if (f == 2)
				wait_results_done();
			fingers = ($urandom_range(9) < 7) ? target[f % 3] : $urandom_range(5);
			send_hand_row(fingers);
		end
		no_gaps <= 1'b0;
	endtask

	task automatic test_random_pixels();
		int w, h;
		w = $urandom_range(40, 21);
		h = $urandom_range(3, 1);
		set_frame(12'(w), 12'(h), 12'($urandom_range(2)));
		repeat (w * h) begin
			if ($urandom_range(1))
				send_kind(1'($urandom_range(1)));
			else
				send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)));
		end
	endtask

	// ------------------------------------------------------------------
	// result checker

	always @(posedge clk) begin : check_results
		marked_px_t seen, want;
		string bad;
		if (arst_n && out_valid && !out_stall) begin
			seen = {out_red, out_green, out_blue, skin_flag, row_done, finger_count,
				frame_done, gesture};
			beats_seen++;
			if (row_done === 1'b1)
				rows_seen++;
			if (frame_done === 1'b1) begin
				frames_seen++;
				if (gesture < 3)
					gest_seen[gesture]++;
			end
			if (marked_px_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected output beat %h", $realtime, seen);
			end else begin
				want = marked_px_q.pop_front();
				bad = "";
				if (seen.red !== want.red) bad = {bad, " red"};
				if (seen.green !== want.green) bad = {bad, " green"};
				if (seen.blue !== want.blue) bad = {bad, " blue"};
				if (seen.skin !== want.skin) bad = {bad, " skin_flag"};
				if (seen.row_end !== want.row_end) bad = {bad, " row_done"};
				if (seen.fingers !== want.fingers) bad = {bad, " finger_count"};
				if (seen.frame_end !== want.frame_end) bad = {bad, " frame_done"};
				if (seen.gest !== want.gest) bad = {bad, " gesture"};
				if (bad != "") begin
					mismatches++;
					if (mismatches <= 10)
						$display({"%0t: beat %0d mismatch in%s\n",
							"  expected rgb %h %h %h skin %b row %b fing %0d frame %b gest %0d\n",
							"  actual   rgb %h %h %h skin %b row %b fing %0d frame %b gest %0d"},
							$realtime, beats_seen, bad,
							want.red, want.green, want.blue, want.skin, want.row_end,
							want.fingers, want.frame_end, want.gest,
							seen.red, seen.green, seen.blue, seen.skin, seen.row_end,
							seen.fingers, seen.frame_end, seen.gest);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// sequence

	initial begin
		arst_n    <= 1'b0;
		wr_en     <= 1'b0;
		wr_index  <= REG_ROW_WIDTH;
		wr_data   <= '0;
		in_valid  <= 1'b0;
		red       <= '0;
		green     <= '0;
		blue      <= '0;
		out_stall <= 1'b0;
		no_gaps   <= 1'b0;
		reset_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_color_extremes();
		test_tiny_frames();
		test_long_run_resize();
		test_finger_threshold();
		test_table_full();
		test_hand_frames();
		test_random_pixels();

		wait_results_done();
		$display("Checked %0d pixels over %0d rows and %0d frames, %0d mismatches.",
			beats_seen, rows_seen, frames_seen, mismatches);
		$display("Gestures seen: stone %0d, scissor %0d, paper %0d.",
			gest_seen[GEST_STONE], gest_seen[GEST_SCISSOR], gest_seen[GEST_PAPER]);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Timeout with %0d pixels still pending.", marked_px_q.size());
		$display("FAILURE");
		$finish;
	end

endmodule
